/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define QNT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define QNT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define QNT_ASSERT_NEXT_ALL(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/qnt_pkg.sv */
package qnt_pkg;

  localparam int TRIG_BITS    = 12;
  localparam int CORDIC_STEPS = 30;
  localparam int TRIG_LATENCY = 39;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [31:0] TILT_COS    = 32'sd929887697;
  localparam logic signed [31:0] TILT_SIN    = 32'sd536870912;

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_WORLD_SCALE = 3'd3,
    REG_ORIGIN_X    = 3'd4,
    REG_ORIGIN_Y    = 3'd5,
    REG_FACING      = 3'd6,
    REG_SPIN        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [30:0] world_scale;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] facing_degrees;
    logic               spin_enabled;
  } cfg_t;

  typedef struct packed {
    logic               lookup_ok;
    logic               node_present;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] node_z;
    logic               has_attachment;
    logic signed [31:0] attach_x;
    logic signed [31:0] attach_y;
    logic signed [31:0] attach_z;
    logic signed [31:0] attach_qx;
    logic signed [31:0] attach_qy;
    logic signed [63:0] attach_qz_qw;
  } item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } res_t;

  typedef struct packed {
    logic [1:0]         quad;
    logic signed [33:0] resid;
    logic               zero;
  } phase_t;

  typedef struct packed {
    logic signed [31:0] cos_q;
    logic signed [31:0] sin_q;
  } trig_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] rnd30(input logic signed [65:0] p);
    logic signed [65:0] r;
    r = (p + 66'sd536870912) >>> 30;
    return sat32(r);
  endfunction

  function automatic logic signed [31:0] rnd16(input logic signed [65:0] p);
    logic signed [65:0] r;
    r = (p + 66'sd32768) >>> 16;
    return sat32(r);
  endfunction

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/qnt_phase.sv */
module qnt_phase (
  input  logic            clk,
  input  qnt_pkg::cfg_t   cfg,
  output qnt_pkg::phase_t phase
);
  import qnt_pkg::*;

  localparam int               NUM_W    = 33;
  localparam logic [NUM_W-1:0] BIAS     = NUM_W'(64'd3019898880);
  // ceil(2^23 / 45) and ceil(2^28 / 45)
  localparam logic [17:0]      RECIP_HI = 18'd186414;
  localparam logic [22:0]      RECIP_LO = 23'd5965233;
  localparam logic [31:0]      HALF     = 32'd1 << (31 - TRIG_BITS);
  localparam logic [31:0]      LOWMASK  = (32'd1 << (32 - TRIG_BITS)) - 32'd1;

  logic [NUM_W-1:0] num;
  logic [34:0]      prod_hi;
  logic [11:0]      q_hi_b;
  logic [16:0]      u_hi;
  logic [15:0]      u_lo;
  logic [16:0]      r_hi;
  logic [21:0]      y_c;
  logic [3:0]       q_hi_c;
  logic [44:0]      prod_lo;
  logic [15:0]      q_lo;
  logic [21:0]      y_d;
  logic [3:0]       q_hi_d;
  logic [21:0]      r_lo;
  logic [19:0]      quo;
  logic [5:0]       rem;
  logic [31:0]      raw;
  logic [31:0]      ph;
  logic [31:0]      ph_next;
  logic [31:0]      qsum;

  // Bias the angle positive by a multiple of the divisor.
  always_ff @(posedge clk) begin
    num <= NUM_W'(cfg.facing_degrees) + BIAS;
  end

  // Divide the upper half by 45.
  assign prod_hi = 35'(num[32:16]) * 35'(RECIP_HI);

  always_ff @(posedge clk) begin
    q_hi_b <= prod_hi[34:23];
    u_hi   <= num[32:16];
    u_lo   <= num[15:0];
  end

  assign r_hi = u_hi - 17'(q_hi_b) * 17'd45;

  always_ff @(posedge clk) begin
    y_c    <= {r_hi[5:0], u_lo};
    q_hi_c <= q_hi_b[3:0];
  end

  // Divide the carried remainder and lower half by 45.
  assign prod_lo = 45'(y_c) * 45'(RECIP_LO);

  always_ff @(posedge clk) begin
    q_lo   <= prod_lo[43:28];
    y_d    <= y_c;
    q_hi_d <= q_hi_c;
  end

  assign r_lo = y_d - 22'(q_lo) * 22'd45;

  always_ff @(posedge clk) begin
    quo <= {q_hi_d, q_lo};
    rem <= r_lo[5:0];
  end

  // 4096/45 = 91 + 1/45, so the fraction of the remainder is 91*r.
  always_ff @(posedge clk) begin
    raw <= {quo, 12'd0} + 32'(rem) * 32'd91;
  end

  always_comb begin
    ph_next = raw;
    if (!cfg.spin_enabled) begin
      ph_next = '0;
    end
    ph_next = (ph_next + HALF) & ~LOWMASK;
  end

  always_ff @(posedge clk) begin
    ph <= ph_next;
  end

  assign qsum = ph + 32'h20000000;

  always_ff @(posedge clk) begin
    phase.quad  <= qsum[31:30];
    phase.resid <= 34'($signed(ph - {qsum[31:30], 30'd0}));
    phase.zero  <= (ph == '0);
  end

endmodule

/* hw/rtl/qnt_cordic.sv */
module qnt_cordic (
  input  logic            clk,
  input  qnt_pkg::phase_t phase,
  output qnt_pkg::trig_t  trig
);
  import qnt_pkg::*;

  logic signed [33:0] cx [CORDIC_STEPS+1];
  logic signed [33:0] cy [CORDIC_STEPS+1];
  logic signed [33:0] cz [CORDIC_STEPS+1];
  logic [1:0]         cq [CORDIC_STEPS+1];
  logic               c0 [CORDIC_STEPS+1];

  assign cx[0] = CORDIC_GAIN;
  assign cy[0] = '0;
  assign cz[0] = phase.resid;
  assign cq[0] = phase.quad;
  assign c0[0] = phase.zero;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [33:0] ang;
    assign ang = $signed(34'(atan_turn(5'(i))));
    always_ff @(posedge clk) begin
      if (cz[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - ang;
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + ang;
      end
      cq[i+1] <= cq[i];
      c0[i+1] <= c0[i];
    end
  end

  always_ff @(posedge clk) begin
    if (c0[CORDIC_STEPS]) begin
      trig.cos_q <= ONE_Q30;
      trig.sin_q <= '0;
    end else begin
      unique case (cq[CORDIC_STEPS])
        2'd0: begin
          trig.cos_q <= cx[CORDIC_STEPS][31:0];
          trig.sin_q <= cy[CORDIC_STEPS][31:0];
        end
        2'd1: begin
          trig.cos_q <= 32'(-cy[CORDIC_STEPS]);
          trig.sin_q <= cx[CORDIC_STEPS][31:0];
        end
        2'd2: begin
          trig.cos_q <= 32'(-cx[CORDIC_STEPS]);
          trig.sin_q <= 32'(-cy[CORDIC_STEPS]);
        end
        default: begin
          trig.cos_q <= cy[CORDIC_STEPS][31:0];
          trig.sin_q <= 32'(-cx[CORDIC_STEPS]);
        end
      endcase
    end
  end

endmodule

/* hw/rtl/qnt_xform.sv */
module qnt_xform (
  input  logic           clk,
  input  logic           rst,
  input  qnt_pkg::cfg_t  cfg,
  input  qnt_pkg::trig_t trig,
  input  logic           in_valid,
  output logic           in_ready,
  input  qnt_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output qnt_pkg::res_t  out_res
);
  import qnt_pkg::*;

  localparam int NST = 15;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  // Stage payloads
  logic               ok_s [NST];
  logic               att_a, att_b;
  logic signed [31:0] l_a [3], l_b [3], l_c [3];
  logic signed [31:0] qa_a [4];
  logic signed [63:0] p_b [8];
  logic signed [31:0] q_c [4], q_d [4], q_e [4], q_f [4];
  logic signed [63:0] p_d [12];
  logic signed [31:0] m_e [12];
  logic signed [31:0] sc_f, vx_f, vy_f, vz_f;
  logic signed [63:0] p_g [12];
  logic signed [31:0] m_h [12];
  logic signed [31:0] t_i [3];
  logic signed [63:0] p_j [4];
  logic signed [31:0] dx_j, dx_k;
  logic signed [31:0] m_k [4];
  logic signed [31:0] d_l [3];
  logic signed [63:0] p_m [3];
  logic signed [31:0] m_n [3];
  logic signed [31:0] w_o [3];
  logic signed [31:0] scale_s;

  assign scale_s = $signed({1'b0, cfg.world_scale});

  always_comb begin
    en[NST-1] = !v[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok_s[0] <= in_item.lookup_ok;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        ok_s[k] <= ok_s[k-1];
      end
    end
  end

  // Local coordinates
  logic signed [31:0] nd [3];
  logic signed [31:0] at [3];
  logic signed [31:0] ct [3];
  always_comb begin
    nd[0] = in_item.node_present ? in_item.node_x : 32'sd0;
    nd[1] = in_item.node_present ? in_item.node_y : 32'sd0;
    nd[2] = in_item.node_present ? in_item.node_z : 32'sd0;
    at[0] = in_item.has_attachment ? in_item.attach_x : 32'sd0;
    at[1] = in_item.has_attachment ? in_item.attach_y : 32'sd0;
    at[2] = in_item.has_attachment ? in_item.attach_z : 32'sd0;
    ct[0] = cfg.center_x;
    ct[1] = cfg.center_y;
    ct[2] = cfg.center_z;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        l_a[i] <= sat32(66'(nd[i]) - 66'(ct[i]) + 66'(at[i]));
      end
      att_a   <= in_item.has_attachment;
      qa_a[0] <= in_item.attach_qx;
      qa_a[1] <= in_item.attach_qy;
      qa_a[2] <= in_item.attach_qz_qw[63:32];
      qa_a[3] <= in_item.attach_qz_qw[31:0];
    end
  end

  // Compose facing and attachment quaternions
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_b[0] <= 64'(trig.cos_q) * 64'(qa_a[0]);
      p_b[1] <= 64'(trig.sin_q) * 64'(qa_a[1]);
      p_b[2] <= 64'(trig.cos_q) * 64'(qa_a[1]);
      p_b[3] <= 64'(trig.sin_q) * 64'(qa_a[0]);
      p_b[4] <= 64'(trig.cos_q) * 64'(qa_a[2]);
      p_b[5] <= 64'(trig.sin_q) * 64'(qa_a[3]);
      p_b[6] <= 64'(trig.cos_q) * 64'(qa_a[3]);
      p_b[7] <= 64'(trig.sin_q) * 64'(qa_a[2]);
      l_b    <= l_a;
      att_b  <= att_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (att_b) begin
        q_c[0] <= rnd30(66'(p_b[0]) - 66'(p_b[1]));
        q_c[1] <= rnd30(66'(p_b[2]) + 66'(p_b[3]));
        q_c[2] <= rnd30(66'(p_b[4]) + 66'(p_b[5]));
        q_c[3] <= rnd30(66'(p_b[6]) - 66'(p_b[7]));
      end else begin
        q_c[0] <= '0;
        q_c[1] <= '0;
        q_c[2] <= trig.sin_q;
        q_c[3] <= trig.cos_q;
      end
      l_c <= l_b;
    end
  end

  // First quaternion product: q * (0, l)
  always_ff @(posedge clk) begin
    if (en[3]) begin
      p_d[0]  <= 64'(q_c[0]) * 64'(l_c[0]);
      p_d[1]  <= 64'(q_c[1]) * 64'(l_c[1]);
      p_d[2]  <= 64'(q_c[2]) * 64'(l_c[2]);
      p_d[3]  <= 64'(q_c[3]) * 64'(l_c[0]);
      p_d[4]  <= 64'(q_c[1]) * 64'(l_c[2]);
      p_d[5]  <= 64'(q_c[2]) * 64'(l_c[1]);
      p_d[6]  <= 64'(q_c[3]) * 64'(l_c[1]);
      p_d[7]  <= 64'(q_c[0]) * 64'(l_c[2]);
      p_d[8]  <= 64'(q_c[2]) * 64'(l_c[0]);
      p_d[9]  <= 64'(q_c[3]) * 64'(l_c[2]);
      p_d[10] <= 64'(q_c[0]) * 64'(l_c[1]);
      p_d[11] <= 64'(q_c[1]) * 64'(l_c[0]);
      q_d     <= q_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 12; i++) begin
        m_e[i] <= rnd30(66'(p_d[i]));
      end
      q_e <= q_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sc_f <= sat32(-66'(m_e[0]) - 66'(m_e[1]) - 66'(m_e[2]));
      vx_f <= sat32(66'(m_e[3]) + 66'(m_e[4]) - 66'(m_e[5]));
      vy_f <= sat32(66'(m_e[6]) - 66'(m_e[7]) + 66'(m_e[8]));
      vz_f <= sat32(66'(m_e[9]) + 66'(m_e[10]) - 66'(m_e[11]));
      q_f  <= q_e;
    end
  end

  // Second product with the conjugate
  always_ff @(posedge clk) begin
    if (en[6]) begin
      p_g[0]  <= 64'(vx_f) * 64'(q_f[3]);
      p_g[1]  <= 64'(sc_f) * 64'(q_f[0]);
      p_g[2]  <= 64'(vy_f) * 64'(q_f[2]);
      p_g[3]  <= 64'(vz_f) * 64'(q_f[1]);
      p_g[4]  <= 64'(vy_f) * 64'(q_f[3]);
      p_g[5]  <= 64'(sc_f) * 64'(q_f[1]);
      p_g[6]  <= 64'(vz_f) * 64'(q_f[0]);
      p_g[7]  <= 64'(vx_f) * 64'(q_f[2]);
      p_g[8]  <= 64'(vz_f) * 64'(q_f[3]);
      p_g[9]  <= 64'(sc_f) * 64'(q_f[2]);
      p_g[10] <= 64'(vx_f) * 64'(q_f[1]);
      p_g[11] <= 64'(vy_f) * 64'(q_f[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 12; i++) begin
        m_h[i] <= rnd30(66'(p_g[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int i = 0; i < 3; i++) begin
        t_i[i] <= sat32(66'(m_h[4*i]) - 66'(m_h[4*i+1]) - 66'(m_h[4*i+2])
                        + 66'(m_h[4*i+3]) + 66'(ct[i]));
      end
    end
  end

  // Tilt about X
  always_ff @(posedge clk) begin
    if (en[9]) begin
      p_j[0] <= 64'(t_i[1]) * 64'(TILT_COS);
      p_j[1] <= 64'(t_i[2]) * 64'(TILT_SIN);
      p_j[2] <= 64'(t_i[2]) * 64'(TILT_COS);
      p_j[3] <= 64'(t_i[1]) * 64'(TILT_SIN);
      dx_j   <= sat32(66'(t_i[0]) - 66'(ct[0]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      for (int i = 0; i < 4; i++) begin
        m_k[i] <= rnd30(66'(p_j[i]));
      end
      dx_k <= dx_j;
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      d_l[0] <= dx_k;
      d_l[1] <= sat32(66'(m_k[0]) - 66'(m_k[1]) - 66'(ct[1]));
      d_l[2] <= sat32(66'(m_k[2]) + 66'(m_k[3]) - 66'(ct[2]));
    end
  end

  // Scale and place
  always_ff @(posedge clk) begin
    if (en[12]) begin
      for (int i = 0; i < 3; i++) begin
        p_m[i] <= 64'(d_l[i]) * 64'(scale_s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[13]) begin
      for (int i = 0; i < 3; i++) begin
        m_n[i] <= rnd16(66'(p_m[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[14]) begin
      if (ok_s[13]) begin
        w_o[0] <= sat32(66'(cfg.origin_x) + 66'(m_n[0]));
        w_o[1] <= sat32(66'(cfg.origin_y) + 66'(m_n[1]));
        w_o[2] <= m_n[2];
      end else begin
        w_o[0] <= '0;
        w_o[1] <= '0;
        w_o[2] <= '0;
      end
    end
  end

  assign out_valid       = v[NST-1];
  assign out_res.ok      = ok_s[NST-1];
  assign out_res.world_x = w_o[0];
  assign out_res.world_y = w_o[1];
  assign out_res.world_z = w_o[2];

endmodule

/* hw/rtl/quaternion_node_transform.sv */
// Mesh node to world space transform.
// Input beats on s_* carry one node with its attachment bone; output beats
// on m_* carry the world position, one result per input beat, in order.
// Configuration is written through cfg_we / cfg_index / cfg_data while no
// beat is in flight, a rule on the user that the block does not enforce;
// registers are center_x/y/z, world_scale, origin_x/y, facing_degrees and
// spin_enabled at indices 0 to 7. Throughput is one beat per cycle while
// m_tready is high, set by the 15-stage multiply/round/sum pipeline.
// The facing sine and cosine come from a free-running 39-stage divider and
// CORDIC pipeline fed by the registers. After reset and after every
// configuration write s_tready stays low while it refills. Reset clears the
// registers to their defaults (world_scale = 1.0) and empties the pipeline.
// When m_tready is low the last stage holds its beat, earlier stages keep
// filling bubbles, and s_tready drops once every stage is full; no beat is
// lost or repeated.
`include "assert_macros.svh"

module quaternion_node_transform (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  qnt_pkg::reg_idx_t cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  // node_x, node_y, node_z, attach_x, attach_y, attach_z, attach_qx,
  // attach_qy, attach_qz_qw
  input  logic [319:0]      s_tdata,
  // lookup_ok, node_present, has_attachment
  input  logic [2:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // world_x, world_y, world_z
  output logic [95:0]       m_tdata,
  // ok
  output logic [0:0]        m_tuser
);
  import qnt_pkg::*;

  localparam int CNT_W = $clog2(TRIG_LATENCY + 1);

  cfg_t             cfg;
  logic [CNT_W-1:0] settle;
  logic             go;
  logic             x_ready;
  item_t            item;
  res_t             res;
  phase_t           phase;
  trig_t            trig;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x       <= '0;
      cfg.center_y       <= '0;
      cfg.center_z       <= '0;
      cfg.world_scale    <= 31'd65536;
      cfg.origin_x       <= '0;
      cfg.origin_y       <= '0;
      cfg.facing_degrees <= '0;
      cfg.spin_enabled   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:    cfg.center_x       <= cfg_data;
        REG_CENTER_Y:    cfg.center_y       <= cfg_data;
        REG_CENTER_Z:    cfg.center_z       <= cfg_data;
        REG_WORLD_SCALE: cfg.world_scale    <= cfg_data[30:0];
        REG_ORIGIN_X:    cfg.origin_x       <= cfg_data;
        REG_ORIGIN_Y:    cfg.origin_y       <= cfg_data;
        REG_FACING:      cfg.facing_degrees <= cfg_data;
        REG_SPIN:        cfg.spin_enabled   <= cfg_data[0];
        default:         cfg.spin_enabled   <= cfg.spin_enabled;
      endcase
    end
  end

  // Hold off input until the trig pipeline reflects the registers.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      settle <= CNT_W'(TRIG_LATENCY);
    end else if (settle != '0) begin
      settle <= settle - CNT_W'(1);
    end
  end

  assign go       = (settle == '0) && !cfg_we;
  assign s_tready = x_ready && go;

  assign item.lookup_ok      = s_tuser[0];
  assign item.node_present   = s_tuser[1];
  assign item.has_attachment = s_tuser[2];
  assign item.node_x         = s_tdata[31:0];
  assign item.node_y         = s_tdata[63:32];
  assign item.node_z         = s_tdata[95:64];
  assign item.attach_x       = s_tdata[127:96];
  assign item.attach_y       = s_tdata[159:128];
  assign item.attach_z       = s_tdata[191:160];
  assign item.attach_qx      = s_tdata[223:192];
  assign item.attach_qy      = s_tdata[255:224];
  assign item.attach_qz_qw   = s_tdata[319:256];

  qnt_phase u_phase (
    .clk   (clk),
    .cfg   (cfg),
    .phase (phase)
  );

  qnt_cordic u_cordic (
    .clk   (clk),
    .phase (phase),
    .trig  (trig)
  );

  qnt_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .trig      (trig),
    .in_valid  (s_tvalid && go),
    .in_ready  (x_ready),
    .in_item   (item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {res.world_z, res.world_y, res.world_x};
  assign m_tuser = res.ok;

  `QNT_ASSERT_NEXT(a_cfg_blocks_input, clk, rst, cfg_we, !s_tready, "input open after config write")
  `QNT_ASSERT_IMP(a_fail_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata == '0, "failed beat not zero")
  `QNT_ASSERT_NEXT_ALL(a_rst_blocks_input, clk, rst, !s_tready, "input open after reset")

endmodule
